### rtl/assert_macros.svh
// Assertion macros shared by the RTL; sampled on clk, disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant checked at every clock edge.
`define PKMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication: when ante holds, cons holds in the same cycle.
`define PKMS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/pkms_pkg.sv
// Shared constants, opcodes and helpers for the prefix k-th match search unit.
`default_nettype none

package pkms_pkg;

	localparam int DICT_DEPTH = 1024;
	localparam int MAX_CHARS  = 8;

	localparam int WORD_W  = 64;
	localparam int LEN_W   = 4;
	localparam int RANK_W  = 11;
	localparam int OUT_W   = 12;
	localparam int OP_W    = 2;
	localparam int ADDR_W  = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
	localparam int CNT_W   = $clog2(DICT_DEPTH + 1);
	localparam int POS_W   = (CNT_W > OUT_W) ? CNT_W : OUT_W;
	localparam int KCMP_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	localparam logic [OUT_W-1:0] NO_MATCH = {OUT_W{1'b1}};

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] r;
		r = (len > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : len;
		return r;
	endfunction

	// Ones over the first len bytes.
	function automatic logic [WORD_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int b = 0; b < MAX_CHARS; b++) begin
			m[b*8 +: 8] = (LEN_W'(b) < len) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

### rtl/prefix_kth_match_search_unit.sv
// Dictionary store and sequential prefix scan answering the k-th match position.
// Clear and append requests are taken while idle; req_stall stays low for them.
// A query raises req_stall while it runs: one stored word per cycle passes the
// single dictionary read port and the shared prefix comparator, stopping early at the
// k-th match. The answer waits in an output register until taken.
// Reset clears the word count and all control state; dictionary contents are not reset.
`default_nettype none
`include "assert_macros.svh"

module prefix_kth_match_search_unit import pkms_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    req_valid,
	output logic                         req_stall,
	input  wire logic [OP_W-1:0]         opcode,
	input  wire logic [WORD_W-1:0]       word_chars,
	input  wire logic [LEN_W-1:0]        word_length,
	input  wire logic [RANK_W-1:0]       rank,
	output logic                         rsp_valid,
	input  wire logic                    rsp_stall,
	output logic signed [OUT_W-1:0]      match_index
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   word_count_q;
	logic [CNT_W-1:0]   rd_addr_q;
	logic [CNT_W-1:0]   seen_q;
	logic [WORD_W-1:0]  prefix_q;
	logic [LEN_W-1:0]   plen_q;
	logic [RANK_W-1:0]  rank_q;
	logic [OUT_W-1:0]   result_q;
	logic               rsp_valid_q;
	logic [OUT_W-1:0]   match_index_q;

	logic [WORD_W-1:0]  dict_words [DICT_DEPTH];
	logic [LEN_W-1:0]   dict_lens  [DICT_DEPTH];

	logic               rd_vld_s1;
	logic [ADDR_W-1:0]  rd_idx_s1;
	logic [WORD_W-1:0]  rd_word_s1;
	logic [LEN_W-1:0]   rd_len_s1;

	logic               accept;
	logic               do_append;
	logic [LEN_W-1:0]   in_len;
	logic [WORD_W-1:0]  in_word;
	logic               issue;
	logic               hit;
	logic               kth_hit;
	logic               scan_empty;
	logic [CNT_W-1:0]   seen_next;
	logic [POS_W-1:0]   pos;
	logic               rsp_free;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign in_len    = clamp_len(word_length);
	assign in_word   = word_chars & byte_mask(in_len);
	assign do_append = accept && (opcode == OP_APPEND) &&
		(word_count_q < CNT_W'(DICT_DEPTH));

	assign issue      = (state_q == ST_SCAN) && (rd_addr_q < word_count_q);
	assign hit        = rd_vld_s1 && (plen_q <= rd_len_s1) &&
		(((rd_word_s1 ^ prefix_q) & byte_mask(plen_q)) == '0);
	assign seen_next  = seen_q + CNT_W'(1);
	assign kth_hit    = hit && (KCMP_W'(seen_next) == KCMP_W'(rank_q));
	assign scan_empty = !rd_vld_s1 && !issue;
	assign pos        = POS_W'(rd_idx_s1) + POS_W'(1);
	assign rsp_free   = !rsp_valid_q || !rsp_stall;

	assign rsp_valid   = rsp_valid_q;
	assign match_index = match_index_q;

	// Dictionary storage: one write port (append), one registered read port (scan).
	always_ff @(posedge clk) begin
		if (do_append) begin
			dict_words[word_count_q[ADDR_W-1:0]] <= in_word;
			dict_lens[word_count_q[ADDR_W-1:0]]  <= in_len;
		end
		if (issue) begin
			rd_word_s1 <= dict_words[rd_addr_q[ADDR_W-1:0]];
			rd_len_s1  <= dict_lens[rd_addr_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_idx_s1 <= rd_addr_q[ADDR_W-1:0];
		end
		if (accept && (opcode == OP_QUERY)) begin
			prefix_q <= in_word;
			plen_q   <= in_len;
			rank_q   <= rank;
		end
		if (state_q == ST_SCAN) begin
			if (kth_hit) begin
				result_q <= pos[OUT_W-1:0];
			end else if (scan_empty) begin
				result_q <= NO_MATCH;
			end
		end
		if (state_q == ST_FINISH && rsp_free) begin
			match_index_q <= result_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			word_count_q <= '0;
			rd_addr_q    <= '0;
			seen_q       <= '0;
			rd_vld_s1    <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (accept) begin
						case (opcode)
							OP_CLEAR: begin
								word_count_q <= '0;
							end
							OP_APPEND: begin
								if (do_append) begin
									word_count_q <= word_count_q + CNT_W'(1);
								end
							end
							OP_QUERY: begin
								rd_addr_q <= '0;
								seen_q    <= '0;
								state_q   <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					// a read still in flight at the k-th match is dropped
					rd_vld_s1 <= issue && !kth_hit;
					if (issue) begin
						rd_addr_q <= rd_addr_q + CNT_W'(1);
					end
					if (hit) begin
						seen_q <= seen_next;
					end
					if (kth_hit || scan_empty) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`PKMS_ASSERT(a_count_bound, word_count_q <= CNT_W'(DICT_DEPTH), "word count above depth")
	`PKMS_ASSERT_IMPL(a_read_written, rd_vld_s1, CNT_W'(rd_idx_s1) < word_count_q, "unwritten read")
	`PKMS_ASSERT_IMPL(a_rsp_from_finish, $rose(rsp_valid_q), $past(state_q) == ST_FINISH, "stray rsp")
	`PKMS_ASSERT_IMPL(a_no_accept_busy, state_q != ST_IDLE, req_stall, "request accepted while busy")

endmodule

`default_nettype wire
